>>> hdl/fsnf_pkg.sv
// Package for the FAT short-name formatter: status codes, character constants
// and the record descriptor passed from the classifier to the character sequencer.
// No dependencies.
package fsnf_pkg;

    // Status codes carried on every result.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_VOLHID  = 3'd1,
        ST_DIREXT  = 3'd2,
        ST_BADDOT  = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_ILLEGAL = 3'd5
    } fsnf_status_t;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Widths fixed by the directory record layout: eight name bytes, three extension bytes.
    localparam int NAME_MAX = 8;
    localparam int EXT_MAX  = 3;
    localparam int NLEN_W   = 4;
    localparam int ELEN_W   = 2;
    localparam int IDX_W    = 4;

    // Descriptor queue depth; a power of two so that the pointers wrap on their own.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        fsnf_status_t                     status;
        logic [NAME_MAX-1:0][7:0]         name;
        logic [EXT_MAX-1:0][7:0]          ext;
        logic [NLEN_W-1:0]                nlen;
        logic [ELEN_W-1:0]                elen;
    } fsnf_desc_t;

endpackage

>>> hdl/fsnf_in_if.sv
// Request channel carrying one FAT directory record (name, extension, attributes).
// Depends on nothing.
interface fsnf_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] name_bytes;
    logic [23:0] ext_bytes;
    logic [7:0]  attr_byte;

    modport source (output valid, output name_bytes, output ext_bytes, output attr_byte,
                    input ready);
    modport sink   (input valid, input name_bytes, input ext_bytes, input attr_byte,
                    output ready);
endinterface

>>> hdl/fsnf_out_if.sv
// Result channel carrying one formatted character with its status and last flag.
// Depends on nothing.
interface fsnf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_char, output status, output last, input ready);
    modport sink   (input valid, input out_char, input status, input last, output ready);
endinterface

>>> hdl/fsnf_front.sv
// Front end of the formatter: accepts a record, turns a leading 0x05 into 0xE5,
// trims, checks it and builds a descriptor. Depends on fsnf_pkg and fsnf_in_if.
module fsnf_front
    import fsnf_pkg::*;
#(
    parameter int NAME_CHARS = 8,
    parameter int EXT_CHARS  = 3
)
(
    fsnf_in_if.sink     records,
    input  logic        q_full,
    output logic        push,
    output fsnf_desc_t  desc
);

    localparam int ATTR_HIDDEN = 1;
    localparam int ATTR_VOLUME = 3;
    localparam int ATTR_SUBDIR = 4;

    logic [7:0]        nm [NAME_MAX];
    logic [7:0]        ex [EXT_MAX];
    logic [NLEN_W-1:0] trim_len;
    logic [NLEN_W-1:0] dot_len;
    logic [NLEN_W-1:0] nlen;
    logic [ELEN_W-1:0] elen;
    logic              dir;
    logic              dot_entry;
    logic              bad_dot;
    logic              illegal;

    function automatic logic legal_char(input logic [7:0] c);
        logic ok;
        ok = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A));
        case (c)
            8'h20, 8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
            8'h2D, 8'h40, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h7D, 8'h7E: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    assign records.ready = !q_full;
    assign push          = records.valid && !q_full;

    always_comb
    begin
        for (int i = 0; i < NAME_MAX; i++)
        begin
            nm[i] = records.name_bytes[8*i +: 8];
        end
        // A leading 0x05 stands for 0xE5 in the directory.
        if (nm[0] == 8'h05)
        begin
            nm[0] = 8'hE5;
        end
        for (int i = 0; i < EXT_MAX; i++)
        begin
            ex[i] = records.ext_bytes[8*i +: 8];
        end

        elen = '0;
        for (int i = 0; i < EXT_CHARS; i++)
        begin
            if (ex[i] != CHAR_SPACE)
            begin
                elen = ELEN_W'(i + 1);
            end
        end
        trim_len = '0;
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if (nm[i] != CHAR_SPACE)
            begin
                trim_len = NLEN_W'(i + 1);
            end
        end

        dir       = records.attr_byte[ATTR_SUBDIR];
        dot_entry = dir && (nm[0] == CHAR_DOT);
        dot_len   = ((NAME_CHARS > 1) && (nm[1] == CHAR_DOT)) ? NLEN_W'(2) : NLEN_W'(1);
        bad_dot   = 1'b0;
        for (int i = 1; i < NAME_CHARS; i++)
        begin
            if ((NLEN_W'(i) >= dot_len) && (nm[i] != CHAR_SPACE))
            begin
                bad_dot = 1'b1;
            end
        end
        nlen = dot_entry ? dot_len : trim_len;

        illegal = 1'b0;
        for (int i = 0; i < NAME_CHARS; i++)
        begin
            if ((NLEN_W'(i) < nlen) && !(legal_char(nm[i]) ||
                (dot_entry && (nm[i] == CHAR_DOT))))
            begin
                illegal = 1'b1;
            end
        end
        for (int i = 0; i < EXT_CHARS; i++)
        begin
            if ((ELEN_W'(i) < elen) && !legal_char(ex[i]))
            begin
                illegal = 1'b1;
            end
        end

        if (records.attr_byte[ATTR_VOLUME] || records.attr_byte[ATTR_HIDDEN])
        begin
            desc.status = ST_VOLHID;
        end
        else if (dir && (elen != '0))
        begin
            desc.status = ST_DIREXT;
        end
        else if (dot_entry && bad_dot)
        begin
            desc.status = ST_BADDOT;
        end
        else if (nlen == '0)
        begin
            desc.status = ST_EMPTY;
        end
        else if (illegal)
        begin
            desc.status = ST_ILLEGAL;
        end
        else
        begin
            desc.status = ST_OK;
        end

        for (int i = 0; i < NAME_MAX; i++)
        begin
            desc.name[i] = nm[i];
        end
        for (int i = 0; i < EXT_MAX; i++)
        begin
            desc.ext[i] = ex[i];
        end
        desc.nlen = nlen;
        desc.elen = elen;
    end

endmodule

>>> hdl/fsnf_queue.sv
// Short descriptor queue between the classifier and the character sequencer.
// Depends on fsnf_pkg.
module fsnf_queue
    import fsnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fsnf_desc_t  push_data,
    output logic        full,
    input  logic        pop,
    output logic        q_valid,
    output fsnf_desc_t  q_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    fsnf_desc_t        mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("descriptor queue over-filled");

    a_pop_only_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("descriptor queue count did not drop on pop");

endmodule

>>> hdl/fsnf_back.sv
// Back end of the formatter: walks one descriptor and emits its characters, one per
// cycle when not stalled, via a registered output. Depends on fsnf_pkg, fsnf_out_if.
module fsnf_back
    import fsnf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  fsnf_desc_t  q_data,
    output logic        pop,
    fsnf_out_if.source  chars
);

    fsnf_desc_t        cur_reg;
    logic              cur_valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              out_valid_reg;
    logic [7:0]        out_char_reg;
    fsnf_status_t      out_status_reg;
    logic              out_last_reg;

    logic [IDX_W-1:0]  total;
    logic [IDX_W-1:0]  ext_idx;
    logic [7:0]        cur_char;
    logic              cur_last;
    logic              out_free;
    logic              emit;
    logic              finish;

    always_comb
    begin
        if (cur_reg.status != ST_OK)
        begin
            total = IDX_W'(1);
        end
        else if (cur_reg.elen != '0)
        begin
            total = IDX_W'(cur_reg.nlen) + IDX_W'(cur_reg.elen) + IDX_W'(1);
        end
        else
        begin
            total = IDX_W'(cur_reg.nlen);
        end

        ext_idx = idx_reg - IDX_W'(cur_reg.nlen) - IDX_W'(1);
        if (cur_reg.status != ST_OK)
        begin
            cur_char = CHAR_NUL;
        end
        else if (idx_reg < IDX_W'(cur_reg.nlen))
        begin
            cur_char = cur_reg.name[idx_reg[2:0]];
        end
        else if (idx_reg == IDX_W'(cur_reg.nlen))
        begin
            cur_char = CHAR_DOT;
        end
        else
        begin
            case (ext_idx[1:0])
                2'd0:    cur_char = cur_reg.ext[0];
                2'd1:    cur_char = cur_reg.ext[1];
                2'd2:    cur_char = cur_reg.ext[2];
                default: cur_char = CHAR_NUL;
            endcase
        end
        cur_last = (idx_reg == total - IDX_W'(1));
    end

    // A new descriptor is taken in the same cycle as the previous one's last character.
    assign out_free = !out_valid_reg || chars.ready;
    assign emit     = cur_valid_reg && out_free;
    assign finish   = emit && cur_last;
    assign pop      = q_valid && (!cur_valid_reg || finish);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
        end
        if (emit)
        begin
            out_char_reg   <= cur_char;
            out_status_reg <= cur_reg.status;
            out_last_reg   <= cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cur_valid_reg <= 1'b1;
                idx_reg       <= '0;
            end
            else if (finish)
            begin
                cur_valid_reg <= 1'b0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chars.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign chars.valid    = out_valid_reg;
    assign chars.out_char = out_char_reg;
    assign chars.status   = out_status_reg;
    assign chars.last     = out_last_reg;

    a_reject_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_last_reg &&
        (out_char_reg == CHAR_NUL)))
        else $error("rejection result is not a single zero character");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (idx_reg < total))
        else $error("character index ran past the end of the record");

endmodule

>>> hdl/fat_short_name_formatter.sv
// FAT 8.3 short-name formatter, top level: one directory record in, its printable
// name out as a run of characters. Depends on fsnf_pkg, the two channel interfaces,
// fsnf_front, fsnf_queue and fsnf_back.
//
// Each request is one FAT directory record. An accepted record gives either its
// printable name, one character per result (trimmed name, a dot when the extension
// is not blank, trimmed extension, with last set on the final character), or a
// single result with a zero character, last set and a non-zero status code. The
// front end checks a record in the cycle that it is accepted and places a
// descriptor in a two-entry queue; it takes a new record every cycle while the
// queue has room. The back end sends one character per cycle while the result
// channel takes them, through a registered output stage, and moves to the next
// descriptor in the cycle that it sends the previous one's last character, so there
// is no gap between records. The result channel therefore sets the sustained rate:
// a record occupies it for one result when rejected and for one result per character
// of its name otherwise, at most twelve. With no stall the record passes through the
// queue, the back end's descriptor register and the registered output stage before
// its first character is offered. The block keeps no state between records.
module fat_short_name_formatter
    import fsnf_pkg::*;
#(
    parameter int NAME_CHARS = 8,
    parameter int EXT_CHARS  = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    fsnf_in_if.sink    records,
    fsnf_out_if.source chars
);

    logic        q_full;
    logic        push;
    fsnf_desc_t  push_desc;
    logic        pop;
    logic        q_valid;
    fsnf_desc_t  q_desc;

    fsnf_front #(
        .NAME_CHARS (NAME_CHARS),
        .EXT_CHARS  (EXT_CHARS)
    ) u_front (
        .records (records),
        .q_full  (q_full),
        .push    (push),
        .desc    (push_desc)
    );

    fsnf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_desc)
    );

    fsnf_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_desc),
        .pop     (pop),
        .chars   (chars)
    );

endmodule
